// ===== rtl/dtc_pkg.sv =====
// ----------------------------------------------------------------------------
// dtc_pkg: shared types and constants of the decision tree classifier
// Command codes, table size and default parameter values.
// ----------------------------------------------------------------------------
package dtc_pkg;

  localparam int MaxDepth    = 10;
  localparam int MaxClasses  = 16;
  localparam int NumFeatures = 256;
  localparam int CountBits   = 20;

  localparam int TableNodes = 1024;
  localparam int NodeBits   = 10;
  localparam int ProbBits   = 17;

  typedef enum logic [1:0] {
    CMD_WR_NODE  = 2'd0,
    CMD_WR_COUNT = 2'd1,
    CMD_WR_FEAT  = 2'd2,
    CMD_CLASSIFY = 2'd3
  } cmd_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// ===== rtl/dtc_divider.sv =====
// ----------------------------------------------------------------------------
// dtc_divider: restoring radix-2 divider
// Computes floor((count << 16) / total), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dtc_divider #(
  parameter int COUNT_BITS = dtc_pkg::CountBits
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COUNT_BITS-1:0] count,
  input  logic [COUNT_BITS-1:0] total,
  output dtc_pkg::div_ctl_t     ctl,
  output logic [COUNT_BITS+15:0] quotient
);
  localparam int NB = COUNT_BITS + 16;
  localparam int CB = $clog2(NB + 1);

  logic [NB-1:0]       num;
  logic [COUNT_BITS:0] rem;
  logic [COUNT_BITS-1:0] den;
  logic [CB-1:0]       cnt;
  logic                busy;
  logic                done;
  logic [COUNT_BITS:0] trial;
  logic [COUNT_BITS+1:0] diff;

  assign trial = {rem[COUNT_BITS-1:0], num[NB-1]};
  assign diff  = {1'b0, trial} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        num  <= {count, 16'd0};
        den  <= total;
        rem  <= '0;
        cnt  <= CB'(NB);
      end else if (busy) begin
        // shift one numerator bit in, subtract when it fits
        if (!diff[COUNT_BITS+1]) begin
          rem <= diff[COUNT_BITS:0];
          num <= {num[NB-2:0], 1'b1};
        end else begin
          rem <= trial;
          num <= {num[NB-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CB'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = num;
  assign ctl.start = start;
  assign ctl.busy  = busy;
  assign ctl.done  = done;
endmodule

// ===== rtl/decision_tree_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// decision_tree_classifier_unit: heap-order decision tree inference
// Node, class count and feature stores, tree walker and class reporter.
// ----------------------------------------------------------------------------
// Commands are accepted when start is high and busy low. A classify visits
// an inner node through S_NREAD, then S_NEVAL for the node data and again
// for the feature (registered node read, then registered feature read) and
// a leaf through S_NREAD and S_NEVAL, for up to MAX_DEPTH levels, then scans
// the leaf's counts (S_CREAD, then S_CEVAL for each class). It then reports
// each class: read the count, start the shared divider and wait in S_DWAIT
// for the quotient. A walk that fails goes to S_ERR, which reports its error
// beat. Each result beat shows for exactly one cycle with result_valid;
// the receiver cannot stall, so it must take every beat as it appears.
module decision_tree_classifier_unit #(
  parameter int MAX_DEPTH    = dtc_pkg::MaxDepth,
  parameter int MAX_CLASSES  = dtc_pkg::MaxClasses,
  parameter int NUM_FEATURES = dtc_pkg::NumFeatures,
  parameter int COUNT_BITS   = dtc_pkg::CountBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [9:0]  node_index,
  input  logic        leaf_flag,
  input  logic [7:0]  feature_index,
  input  logic signed [31:0] threshold,
  input  logic [19:0] total_count,
  input  logic [3:0]  class_index,
  input  logic [19:0] class_count,
  input  logic signed [31:0] feature_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  output logic        result_valid,
  output logic [3:0]  class_index_res,
  output logic [16:0] probability,
  output logic [3:0]  predicted_class,
  output logic        status,
  output logic        last
);
  localparam int NB   = dtc_pkg::NodeBits;
  localparam int CLB  = $clog2(MAX_CLASSES);
  localparam int FB   = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int DB   = $clog2(MAX_DEPTH + 1);
  localparam int CAP  = (MAX_CLASSES < 16) ? MAX_CLASSES : 16;
  localparam int QB   = COUNT_BITS + 16;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_NREAD = 8'b00000010,
    S_NEVAL = 8'b00000100,
    S_CREAD = 8'b00001000,
    S_CEVAL = 8'b00010000,
    S_DSTRT = 8'b00100000,
    S_DWAIT = 8'b01000000,
    S_ERR   = 8'b10000000
  } state_t;

  // Stores
  logic                  node_leaf_mem  [dtc_pkg::TableNodes];
  logic [7:0]            node_fsel_mem  [dtc_pkg::TableNodes];
  logic [31:0]           node_split_mem [dtc_pkg::TableNodes];
  logic [COUNT_BITS-1:0] node_total_mem [dtc_pkg::TableNodes];
  logic [COUNT_BITS-1:0] count_mem [dtc_pkg::TableNodes*(2**CLB)];
  logic [31:0]           feat_mem  [NUM_FEATURES];

  state_t state;
  logic [4:0] num_classes;
  logic [NB-1:0] node;
  logic [DB-1:0] level;
  logic [CLB-1:0] cls;
  logic [CLB-1:0] best;
  logic [COUNT_BITS-1:0] best_cnt;
  logic [4:0] n_eff;
  logic scan_pass; // 0: argmax scan, 1: probability pass

  logic                  rd_leaf;
  logic [7:0]            rd_fsel;
  logic [31:0]           rd_split;
  logic [COUNT_BITS-1:0] rd_total;
  logic [31:0]           rd_feat;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [NB-1:0]         rd_node;

  logic accept;
  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) num_classes <= 5'd2;
    else if (cfg_valid && cfg_ready) num_classes <= cfg_data;
  end

  // Effective class count: zero acts as one, capped.
  always_comb begin
    if (num_classes == 5'd0) n_eff = 5'd1;
    else if (num_classes > 5'(CAP)) n_eff = 5'(CAP);
    else n_eff = num_classes;
  end

  // Write ports
  logic [NB+CLB-1:0] cnt_waddr;
  logic [NB+CLB-1:0] cnt_raddr;
  assign cnt_waddr = {node_index, CLB'(class_index)};
  assign cnt_raddr = {node, cls};

  always_ff @(posedge clk) begin
    if (accept && cmd == dtc_pkg::CMD_WR_NODE) begin
      node_leaf_mem[node_index]  <= leaf_flag;
      node_fsel_mem[node_index]  <= feature_index;
      node_split_mem[node_index] <= threshold;
      node_total_mem[node_index] <= COUNT_BITS'(total_count);
    end
    if (accept && cmd == dtc_pkg::CMD_WR_COUNT && 32'(class_index) < MAX_CLASSES)
      count_mem[cnt_waddr] <= COUNT_BITS'(class_count);
    if (accept && cmd == dtc_pkg::CMD_WR_FEAT && 32'(feature_index) < NUM_FEATURES)
      feat_mem[FB'(feature_index)] <= feature_value;
  end

  // Registered reads
  always_ff @(posedge clk) begin
    rd_leaf  <= node_leaf_mem[node];
    rd_fsel  <= node_fsel_mem[node];
    rd_split <= node_split_mem[node];
    rd_total <= node_total_mem[node];
    rd_cnt   <= count_mem[cnt_raddr];
    rd_node  <= node;
  end

  // Feature read needs the node's select; second stage of a node visit.
  logic fsel_ok;
  assign fsel_ok = 32'(rd_fsel) < NUM_FEATURES;
  always_ff @(posedge clk) begin
    rd_feat <= feat_mem[FB'(rd_fsel)];
  end

  // Shared divider
  dtc_pkg::div_ctl_t div_ctl;
  logic [QB-1:0] quot;
  logic div_go;
  assign div_go = (state == S_DSTRT);

  dtc_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .count    (rd_cnt),
    .total    (rd_total),
    .ctl      (div_ctl),
    .quotient (quot)
  );

  logic signed [31:0] resp;
  logic [NB+1:0] child;
  logic feat_phase;
  assign resp  = fsel_ok ? $signed(rd_feat) : 32'sd0;
  assign child = {1'b0, rd_node, 1'b0} +
                 ((resp < $signed(rd_split)) ? (NB+2)'(1) : (NB+2)'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      feat_phase   <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && cmd == dtc_pkg::CMD_CLASSIFY) begin
            node       <= '0;
            level      <= '0;
            feat_phase <= 1'b0;
            state      <= S_NREAD;
          end
        end
        S_NREAD: begin
          // hold while the node read settles
          state <= S_NEVAL;
        end
        S_NEVAL: begin
          if (!feat_phase) begin
            // leaf check as soon as node data is in; else wait for feature
            if (rd_leaf) begin
              cls       <= '0;
              best      <= '0;
              best_cnt  <= '0;
              scan_pass <= 1'b0;
              state     <= S_CREAD;
            end else begin
              feat_phase <= 1'b1;
            end
          end else begin
            feat_phase <= 1'b0;
            if (child >= (NB+2)'(dtc_pkg::TableNodes) || level == DB'(MAX_DEPTH - 1)) begin
              state <= S_ERR;
            end else begin
              node  <= child[NB-1:0];
              level <= level + 1'b1;
              state <= S_NREAD;
            end
          end
        end
        S_CREAD: state <= S_CEVAL;
        S_CEVAL: begin
          if (!scan_pass) begin
            // first class with the largest count
            if (cls == '0 || rd_cnt > best_cnt) begin
              best     <= cls;
              best_cnt <= rd_cnt;
            end
            if (5'(cls) + 5'd1 == n_eff) begin
              scan_pass <= 1'b1;
              cls       <= '0;
              state     <= S_CREAD;
            end else begin
              cls   <= cls + 1'b1;
              state <= S_CREAD;
            end
          end else begin
            state <= S_DSTRT;
          end
        end
        S_DSTRT: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_ctl.done) begin
            result_valid    <= 1'b1;
            class_index_res <= 4'(cls);
            predicted_class <= 4'(best);
            status          <= 1'b0;
            if (rd_total == '0) probability <= '0;
            else if (quot > QB'(65536)) probability <= 17'd65536;
            else probability <= quot[16:0];
            if (5'(cls) + 5'd1 == n_eff) begin
              last  <= 1'b1;
              state <= S_IDLE;
            end else begin
              last  <= 1'b0;
              cls   <= cls + 1'b1;
              state <= S_CREAD;
            end
          end
        end
        S_ERR: begin
          result_valid    <= 1'b1;
          class_index_res <= '0;
          predicted_class <= '0;
          probability     <= '0;
          status          <= 1'b1;
          last            <= 1'b1;
          state           <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
